// File: hdl/ipsf_pkg.sv
// Shared types and constants of the interval pair slot finder.
package ipsf_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int COORD_W   = 32;
	localparam int COLOUR_W  = 24;
	localparam int SLOT_W    = 9;

	localparam logic REQ_FIND   = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NONE  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SETTLE,
		S_SHIFT,
		S_PLACE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0]  up;
		logic [COORD_W-1:0]  down;
		logic [COLOUR_W-1:0] colour;
	} entry_t;

endpackage

// File: hdl/ipsf_if.sv
// Request and response channel interfaces of the interval pair slot finder.
interface ipsf_req_if import ipsf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [COORD_W-1:0]  up_coord;
	logic [COORD_W-1:0]  down_coord;
	logic [COLOUR_W-1:0] colour_rgb;
	logic [SLOT_W-1:0]   slot;

	modport source (output valid, req_type, up_coord, down_coord, colour_rgb, slot,
		input ready);
	modport sink (input valid, req_type, up_coord, down_coord, colour_rgb, slot,
		output ready);
endinterface

interface ipsf_rsp_if import ipsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] found_slot;
	logic [SLOT_W-1:0] entry_count;

	modport source (output valid, status, found_slot, entry_count, input ready);
	modport sink (input valid, status, found_slot, entry_count, output ready);
endinterface

// File: hdl/interval_pair_slot_finder.sv
// Ordered pair table with slot search and shifting insert.
// Find: searches the n entries for a slot where the pair fits, one table read per cycle.
// Insert: entries from the slot upward move up one place, then the new pair is written at the slot.
// Table full and slot beyond count: the request goes straight to the finish step, with no table access.
// One request in flight; a result waits in the finish step while the last response stalls.
// Reset clears the entry count and the control state; table contents are not cleared.
module interval_pair_slot_finder import ipsf_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ipsf_req_if.sink  req,
	ipsf_rsp_if.source rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = $clog2(TABLE_DEPTH + 2);

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] s_q;
	logic [COORD_W-1:0] u_q, d_q;
	logic [COLOUR_W-1:0] c_q;

	logic          rv_s1, rin_s1;
	logic [KW-1:0] rk_s1;
	logic          ev_s2;
	logic [KW-1:0] j_s2;

	entry_t win_q [4];
	logic [3:0] wv_q;

	logic f0_q, fn_q, f1_q, fnm1_q, fmid_q;
	logic [CW-1:0] mslot_q;

	status_t res_status_q;
	logic [CW-1:0] res_slot_q;

	logic rsp_valid_q;
	status_t rsp_status_q;
	logic [SLOT_W-1:0] rsp_slot_q, rsp_count_q;

	logic [31:0] cnt32, k32, j32, ins_slot32;
	logic full, beyond, fit, out_free, accept;

	assign cnt32      = 32'(cnt_q);
	assign k32        = 32'(k_q);
	assign j32        = 32'(j_s2);
	assign ins_slot32 = (cnt_q == '0) ? 32'd0 : 32'(req.slot);
	assign full       = cnt32 >= TABLE_DEPTH;
	assign beyond     = ins_slot32 > cnt32;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign accept     = req.valid && req.ready;

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_slot  = rsp_slot_q;
	assign rsp.entry_count = rsp_count_q;

	assign fit = (!(wv_q[1] && wv_q[2]) || (win_q[1].down < win_q[2].up)) &&
		(!wv_q[1] || (u_q > win_q[1].up && d_q > win_q[1].down &&
			(!wv_q[0] || u_q > win_q[0].down))) &&
		(!wv_q[2] || (u_q < win_q[2].up && d_q < win_q[2].down &&
			(!wv_q[3] || d_q < win_q[3].up)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_FIND)
						state_d = S_SCAN;
					else if (full || beyond)
						state_d = S_FINISH;
					else if (cnt32 > ins_slot32)
						state_d = S_SHIFT;
					else
						state_d = S_PLACE;
				end
			end
			S_SCAN: begin
				if (k32 == cnt32 + 32'd1)
					state_d = S_SETTLE;
			end
			S_SETTLE: begin
				if (!rv_s1 && !ev_s2)
					state_d = S_FINISH;
			end
			S_SHIFT: begin
				if (k32 == 32'(s_q))
					state_d = S_PLACE;
			end
			S_PLACE: begin
				if (!rv_s1)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// table memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN && k32 < cnt32) || state_q == S_SHIFT)
			rdata_q <= mem[k_q[AW-1:0]];
		if (rv_s1 && state_q != S_SCAN && state_q != S_SETTLE)
			mem[AW'(32'(rk_s1) + 32'd1)] <= rdata_q;
		else if (state_q == S_PLACE && !rv_s1)
			mem[s_q] <= '{up: u_q, down: d_q, colour: c_q};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_q <= req.up_coord;
			d_q <= req.down_coord;
			c_q <= req.colour_rgb;
			s_q <= AW'(ins_slot32);
		end
		rk_s1  <= k_q;
		rin_s1 <= k32 < cnt32;
		if (rv_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= rdata_q;
		end
		j_s2 <= KW'(32'(rk_s1) - 32'd1);
		if (ev_s2 && fit && j32 >= 32'd2 && j32 + 32'd2 <= cnt32 && !fmid_q)
			mslot_q <= CW'(j32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			k_q          <= '0;
			rv_s1        <= 1'b0;
			ev_s2        <= 1'b0;
			wv_q         <= '0;
			f0_q         <= 1'b0;
			fn_q         <= 1'b0;
			f1_q         <= 1'b0;
			fnm1_q       <= 1'b0;
			fmid_q       <= 1'b0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_slot_q   <= '0;
			rsp_count_q  <= '0;
		end else begin
			rv_s1 <= (state_q == S_SCAN) || (state_q == S_SHIFT);
			ev_s2 <= rv_s1 && (state_q == S_SCAN || state_q == S_SETTLE) && rk_s1 != '0;
			if (rv_s1)
				wv_q <= {rin_s1, wv_q[3:1]};
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						wv_q   <= '0;
						f0_q   <= 1'b0;
						fn_q   <= 1'b0;
						f1_q   <= 1'b0;
						fnm1_q <= 1'b0;
						fmid_q <= 1'b0;
						if (req.req_type == REQ_FIND)
							k_q <= '0;
						else
							k_q <= KW'(cnt32 - 32'd1);
						res_slot_q <= '0;
						if (req.req_type == REQ_INSERT && full)
							res_status_q <= ST_FULL;
						else if (req.req_type == REQ_INSERT && beyond)
							res_status_q <= ST_RANGE;
						else
							res_status_q <= ST_OK;
					end
				end
				S_SCAN: begin
					k_q <= k_q + 1'b1;
				end
				S_SHIFT: begin
					k_q <= k_q - 1'b1;
				end
				S_PLACE: begin
					if (!rv_s1) begin
						cnt_q      <= cnt_q + 1'b1;
						res_slot_q <= CW'(s_q);
					end
				end
				S_SETTLE: begin
					if (!rv_s1 && !ev_s2) begin
						res_status_q <= ST_OK;
						if (f0_q)
							res_slot_q <= '0;
						else if (fn_q)
							res_slot_q <= cnt_q;
						else if (f1_q)
							res_slot_q <= CW'(1);
						else if (fnm1_q)
							res_slot_q <= cnt_q - 1'b1;
						else if (fmid_q)
							res_slot_q <= mslot_q;
						else
							res_status_q <= ST_NONE;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						rsp_status_q <= res_status_q;
						rsp_slot_q   <= SLOT_W'(res_slot_q);
						rsp_count_q  <= SLOT_W'(cnt_q);
					end
				end
				default: ;
			endcase
			if (ev_s2 && fit) begin
				if (j32 == 32'd0)
					f0_q <= 1'b1;
				if (j32 == cnt32)
					fn_q <= 1'b1;
				if (j32 == 32'd1)
					f1_q <= 1'b1;
				if (j32 == cnt32 - 32'd1)
					fnm1_q <= 1'b1;
				if (j32 >= 32'd2 && j32 + 32'd2 <= cnt32)
					fmid_q <= 1'b1;
			end
			if (state_q == S_FINISH && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/ipsf_checker.sv
// Port-level checks of the interval pair slot finder and their binding.
module ipsf_checker import ipsf_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        status,
	input logic [SLOT_W-1:0] found_slot,
	input logic [SLOT_W-1:0] entry_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(found_slot) && $stable(entry_count))
		else $error("response changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> found_slot == '0)
		else $error("failed request reports a slot");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> 32'(entry_count) == (TABLE_DEPTH & 511))
		else $error("full status with table not full");

	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OK && TABLE_DEPTH < 512 |-> found_slot <= entry_count)
		else $error("slot beyond entry count");

endmodule

bind interval_pair_slot_finder ipsf_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ipsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.found_slot  (rsp.found_slot),
	.entry_count (rsp.entry_count)
);

// File: test/interval_pair_slot_finder_tb.sv
// Self-checking testbench of the interval pair slot finder against a predicted table.
module interval_pair_slot_finder_tb;
	import ipsf_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int STALL_STOP = 6000;
	localparam int TAIL_WAIT  = 400;
	localparam int HOLD_LEN   = 600;
	localparam logic [31:0] TOP = 32'hFFFF_FFFF;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] count;
		int                phase;
		bit                hold;
	} answer_t;

	typedef struct {
		logic                req_type;
		logic [COORD_W-1:0]  up;
		logic [COORD_W-1:0]  down;
		logic [COLOUR_W-1:0] colour;
		logic [SLOT_W-1:0]   slot;
		bit                  drain;
		answer_t             ans;
	} request_t;

	logic clk;
	logic arst_n;

	ipsf_req_if req ();
	ipsf_rsp_if rsp ();

	interval_pair_slot_finder #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [COORD_W-1:0]  tab_up [DEPTH];
	logic [COORD_W-1:0]  tab_down [DEPTH];
	logic [COLOUR_W-1:0] tab_colour [DEPTH];
	int                  tab_count;

	request_t request_q [$];
	answer_t  answer_q [$];
	int       errors;
	int       stall_cycles;
	int       hold_left;
	bit       hold_done;
	int       gen_phase;
	bit       gen_drain;
	bit       gen_hold;

	function automatic logic [31:0] max32(logic [31:0] a, logic [31:0] b);
		return a > b ? a : b;
	endfunction

	function automatic logic [31:0] min32(logic [31:0] a, logic [31:0] b);
		return a < b ? a : b;
	endfunction

	function automatic bit lies_above(int k, logic [31:0] u, logic [31:0] d, bit wide);
		if (wide)
			return u > max32(tab_down[k-1], tab_up[k]) && d > tab_down[k];
		return tab_up[k] < u && tab_down[k] < d;
	endfunction

	function automatic bit lies_below(int k, logic [31:0] u, logic [31:0] d, bit wide);
		if (wide)
			return u < tab_up[k] && d < min32(tab_down[k], tab_up[k+1]);
		return u < tab_up[k] && d < tab_down[k];
	endfunction

	function automatic bit hole_open(int k);
		return tab_down[k] < tab_up[k+1];
	endfunction

	function automatic int fit_slot(logic [31:0] u, logic [31:0] d);
		int n;
		n = tab_count;
		if (n == 0)
			return 0;
		if (n == 1) begin
			if (lies_below(0, u, d, 0)) return 0;
			if (lies_above(0, u, d, 0)) return 1;
			return -1;
		end
		if (lies_below(0, u, d, 1)) return 0;
		if (lies_above(n - 1, u, d, 1)) return n;
		if (n == 2) begin
			if (hole_open(0) && lies_above(0, u, d, 0) && lies_below(1, u, d, 0))
				return 1;
			return -1;
		end
		if (hole_open(0) && lies_above(0, u, d, 0) && lies_below(1, u, d, 1))
			return 1;
		if (hole_open(n - 2) && lies_above(n - 2, u, d, 1) && lies_below(n - 1, u, d, 0))
			return n - 1;
		for (int i = 1; i + 2 < n; i++)
			if (hole_open(i) && lies_above(i, u, d, 1) && lies_below(i + 1, u, d, 1))
				return i + 1;
		return -1;
	endfunction

	task automatic queue_request(logic kind, logic [31:0] u, logic [31:0] d,
		logic [23:0] c, logic [8:0] s);
		request_t r;
		int       where;
		int       pos;
		r.req_type = kind;
		r.up = u;
		r.down = d;
		r.colour = c;
		r.slot = s;
		r.drain = gen_drain;
		r.ans.phase = gen_phase;
		r.ans.hold = gen_hold;
		r.ans.status = ST_OK;
		r.ans.slot = '0;
		gen_drain = 0;
		gen_hold = 0;
		if (kind == REQ_FIND) begin
			where = fit_slot(u, d);
			if (where < 0)
				r.ans.status = ST_NONE;
			else
				r.ans.slot = where[8:0];
		end else if (tab_count >= DEPTH) begin
			r.ans.status = ST_FULL;
		end else begin
			pos = (tab_count == 0) ? 0 : int'(s);
			if (pos > tab_count) begin
				r.ans.status = ST_RANGE;
			end else begin
				for (int i = tab_count; i > pos; i--) begin
					tab_up[i] = tab_up[i-1];
					tab_down[i] = tab_down[i-1];
					tab_colour[i] = tab_colour[i-1];
				end
				tab_up[pos] = u;
				tab_down[pos] = d;
				tab_colour[pos] = c;
				tab_count++;
				r.ans.slot = pos[8:0];
			end
		end
		r.ans.count = tab_count[8:0];
		request_q.push_back(r);
	endtask

	task automatic queue_fitting_pair();
		longint lo;
		longint hi;
		logic [31:0] u;
		logic [31:0] d;
		int p;
		int where;
		p = $urandom_range(tab_count, 0);
		lo = (p > 0) ? longint'(max32(tab_up[p-1], tab_down[p-1])) : 0;
		hi = (p < tab_count) ? longint'(min32(tab_up[p], tab_down[p])) : longint'(TOP);
		if (hi - lo < 6) begin
			u = $urandom;
			d = $urandom;
		end else begin
			u = 32'(lo + 1 + $urandom_range(32'((hi - lo - 2) / 2), 0));
			d = 32'(longint'(u) + 1 + $urandom_range(32'(hi - longint'(u) - 2), 0));
		end
		if ($urandom_range(1, 0))
			queue_request(REQ_FIND, u, d, 24'($urandom), 9'($urandom));
		where = fit_slot(u, d);
		if ($urandom_range(3, 0) != 0)
			queue_request(REQ_INSERT, u, d, 24'($urandom),
				(where < 0) ? p[8:0] : where[8:0]);
	endtask

	task automatic queue_random_phase(int phase, int items);
		int start;
		gen_phase = phase;
		start = request_q.size();
		while (request_q.size() - start < items) begin
			case ($urandom_range(9, 0))
				0: queue_request(REQ_FIND, $urandom, $urandom, 24'($urandom), 9'($urandom));
				1: queue_request(REQ_INSERT, $urandom, $urandom, 24'($urandom),
					9'($urandom_range(2 * tab_count + 2, 0)));
				2: begin
					gen_drain = 1;
					queue_fitting_pair();
				end
				default: queue_fitting_pair();
			endcase
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		req.valid = 0;
		req.req_type = REQ_FIND;
		req.up_coord = '0;
		req.down_coord = '0;
		req.colour_rgb = '0;
		req.slot = '0;
		rsp.ready = 0;
		errors = 0;
		tab_count = 0;
		gen_phase = 0;
		gen_drain = 0;
		gen_hold = 0;

		queue_request(REQ_FIND, 5, 6, 0, 0);
		queue_request(REQ_INSERT, 100, 200, 24'hFFFFFF, 7);
		queue_request(REQ_INSERT, 1, 2, 0, 5);
		queue_request(REQ_FIND, 50, 150, 0, 0);
		queue_request(REQ_FIND, 300, 400, 0, 0);
		queue_request(REQ_FIND, 150, 100, 0, 0);
		queue_request(REQ_INSERT, 1000, 2000, 24'h000000, 1);
		queue_request(REQ_FIND, 300, 500, 0, 0);
		queue_request(REQ_FIND, 0, 0, 0, 0);
		queue_request(REQ_FIND, 3000, 3000, 0, 0);
		queue_request(REQ_FIND, TOP, TOP, 24'hFFFFFF, 9'h1FF);
		queue_request(REQ_INSERT, 5000, 6000, 24'h123456, 2);
		queue_request(REQ_FIND, 300, 500, 0, 0);
		queue_request(REQ_FIND, 2500, 3000, 0, 0);
		queue_request(REQ_FIND, 50, 60, 0, 0);
		queue_request(REQ_INSERT, 9000, 9500, 24'hABCDEF, 3);
		queue_request(REQ_FIND, 2500, 3000, 0, 0);
		queue_request(REQ_FIND, 6500, 7000, 0, 0);
		queue_request(REQ_FIND, 8000, 10, 0, 0);
		queue_request(REQ_INSERT, TOP, TOP, 24'hFFFFFF, 9'd256);
		queue_request(REQ_INSERT, TOP, TOP, 24'hFFFFFF, 4);
		queue_request(REQ_FIND, TOP, TOP, 0, 0);

		queue_random_phase(1, 130);
		gen_hold = 1;
		queue_random_phase(2, 130);
		queue_random_phase(3, 130);
		while (tab_count < DEPTH)
			queue_request(REQ_INSERT, $urandom, $urandom, 24'($urandom), tab_count[8:0]);
		queue_request(REQ_INSERT, 1, 2, 3, 0);
		queue_request(REQ_INSERT, 1, 2, 3, 9'd256);
		queue_request(REQ_FIND, $urandom, $urandom, 0, 0);
		queue_request(REQ_FIND, TOP, TOP, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (request_q.size() == 0 && answer_q.size() == 0);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	function automatic int sender_idle(int phase);
		case (phase)
			1: return 35;
			2: return 61;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle(int phase);
		case (phase)
			1: return 61;
			2: return 35;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (!req.valid || req.ready) begin
				if (req.valid) begin
					answer_q.push_back(request_q[0].ans);
					void'(request_q.pop_front());
				end
				if (request_q.size() != 0
					&& !(request_q[0].drain && answer_q.size() != 0)
					&& $urandom_range(99, 0) >= sender_idle(request_q[0].ans.phase)) begin
					req.valid <= 1;
					req.req_type <= request_q[0].req_type;
					req.up_coord <= request_q[0].up;
					req.down_coord <= request_q[0].down;
					req.colour_rgb <= request_q[0].colour;
					req.slot <= request_q[0].slot;
				end else begin
					req.valid <= 0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unexpected response", 1, 0);
				end else begin
					want = answer_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", int'(rsp.status), int'(want.status));
					if (rsp.found_slot !== want.slot)
						report_mismatch("found_slot", int'(rsp.found_slot), int'(want.slot));
					if (rsp.entry_count !== want.count)
						report_mismatch("entry_count", int'(rsp.entry_count),
							int'(want.count));
				end
			end
			if (!hold_done && answer_q.size() != 0 && answer_q[0].hold) begin
				hold_done <= 1;
				hold_left <= HOLD_LEN;
				rsp.ready <= 0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= 0;
			end else begin
				rsp.ready <= $urandom_range(99, 0) >=
					receiver_idle(answer_q.size() != 0 ? answer_q[0].phase : 3);
			end
		end else begin
			hold_left <= 0;
			hold_done <= 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_STOP) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
